// ===== design/gdd_pkg.sv =====
// shared types, constants and calendar helper functions for the day difference block
package gdd_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 21;
    localparam int DOY_W   = 9;
    localparam int ERA_W   = 4;
    localparam int YOE_W   = 9;

    localparam logic [YEAR_W-1:0]  FIRST_YEAR      = 12'd1900;
    localparam logic [YEAR_W-1:0]  RESET_CUR_YEAR  = 12'd2024;
    localparam logic [MONTH_W-1:0] MONTH_JAN       = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC       = 4'd12;
    localparam logic [COUNT_W-1:0] DAYS_PER_ERA    = 21'd146097;
    localparam logic [COUNT_W-1:0] DAYS_PER_YEAR   = 21'd365;
    localparam logic [YEAR_W-1:0]  YEARS_PER_ERA   = 12'd400;

    typedef struct packed {
        logic [YEAR_W-1:0]  first_year;
        logic [MONTH_W-1:0] first_month;
        logic [DAY_W-1:0]   first_day;
        logic [YEAR_W-1:0]  second_year;
        logic [MONTH_W-1:0] second_month;
        logic [DAY_W-1:0]   second_day;
    } t_gdd_req;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               first_valid;
        logic               second_valid;
    } t_gdd_rsp;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] day_num;
    } t_gdd_lane;

    // exact x / 25 for any 10-bit x, by reciprocal multiply
    function automatic logic [5:0] div25(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd1311;
        return p[20:15];
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

    // days before the month in a march-based year
    function automatic logic [DOY_W-1:0] doy_off(input logic [MONTH_W-1:0] mp);
        logic [DOY_W-1:0] off;
        case (mp)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

// ===== design/gdd_lane.sv =====
// one date lane: range checks and day number over three pipeline stages
module gdd_lane import gdd_pkg::*; #(
    parameter int YEAR_BITS = 12
) (
    input  logic               i_clk,
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [MONTH_W-1:0] i_month,
    input  logic [DAY_W-1:0]   i_day,
    input  logic [YEAR_W-1:0]  i_cur_year,
    output t_gdd_lane          o_lane
);

    localparam int YB = (YEAR_BITS < YEAR_W) ? YEAR_BITS : YEAR_W;
    localparam logic [YEAR_W-1:0] YMASK = YEAR_W'((1 << YB) - 1);

    logic [YEAR_W-1:0]  y;
    logic [9:0]         x4;
    logic [5:0]         q;
    logic               div4;
    logic               c100;
    logic               c400;
    logic               leap;
    logic [DAY_W-1:0]   len;
    logic               ok;
    logic [YEAR_W-1:0]  yy;
    logic [MONTH_W-1:0] mp;

    logic               r_s1_ok;
    logic [YEAR_W-1:0]  r_s1_yy;
    logic [ERA_W-1:0]   r_s1_era;
    logic [MONTH_W-1:0] r_s1_mp;
    logic [DAY_W-1:0]   r_s1_day;

    logic [YEAR_W-1:0]  yoe_full;
    logic [DOY_W-1:0]   doy;

    logic               r_s2_ok;
    logic [ERA_W-1:0]   r_s2_era;
    logic [YOE_W-1:0]   r_s2_yoe;
    logic [DOY_W-1:0]   r_s2_doy;

    logic [5:0]         c;
    logic [COUNT_W-1:0] n_day_num;

    // stage 1: checks, march-based year and era
    always_comb begin
        y    = i_year & YMASK;
        x4   = y[YEAR_W-1:2];
        q    = div25(x4);
        div4 = (y[1:0] == 2'd0);
        c100 = div4 && (x4 == 10'(q) * 10'd25);
        c400 = c100 && (q[1:0] == 2'd0);
        leap = (div4 && !c100) || c400;
        len  = month_len(i_month, leap);
        ok   = (y >= FIRST_YEAR) && (y <= i_cur_year)
            && (i_month >= MONTH_JAN) && (i_month <= MONTH_DEC)
            && (i_day != '0) && (i_day <= len);
        yy   = (i_month <= MONTH_FEB) ? y - 12'd1 : y;
        mp   = (i_month > MONTH_FEB) ? i_month - 4'd3 : i_month + 4'd9;
    end

    always_ff @(posedge i_clk) begin
        r_s1_ok  <= ok;
        r_s1_yy  <= yy;
        r_s1_era <= ERA_W'(div25({2'b00, yy[YEAR_W-1:4]}));
        r_s1_mp  <= mp;
        r_s1_day <= i_day;
    end

    // stage 2: year of era and day of year
    always_comb begin
        yoe_full = r_s1_yy - 12'(r_s1_era) * YEARS_PER_ERA;
        doy      = doy_off(r_s1_mp) + 9'(r_s1_day) - 9'd1;
    end

    always_ff @(posedge i_clk) begin
        r_s2_ok  <= r_s1_ok;
        r_s2_era <= r_s1_era;
        r_s2_yoe <= yoe_full[YOE_W-1:0];
        r_s2_doy <= doy;
    end

    // stage 3: sum into the day number
    always_comb begin
        c = div25({3'b000, r_s2_yoe[YOE_W-1:2]});
        n_day_num = 21'(r_s2_era) * DAYS_PER_ERA + 21'(r_s2_yoe) * DAYS_PER_YEAR
                  + 21'(r_s2_yoe[YOE_W-1:2]) - 21'(c) + 21'(r_s2_doy);
    end

    always_ff @(posedge i_clk) begin
        o_lane.ok      <= r_s2_ok;
        o_lane.day_num <= n_day_num;
    end

endmodule

// ===== design/gdd_merge.sv =====
// merge stage: absolute difference of the two lane day numbers, gated by validity
module gdd_merge import gdd_pkg::*; (
    input  logic      i_clk,
    input  t_gdd_lane i_lane_a,
    input  t_gdd_lane i_lane_b,
    output t_gdd_rsp  o_rsp
);

    logic [COUNT_W-1:0] diff;

    always_comb begin
        if (i_lane_a.day_num > i_lane_b.day_num) begin
            diff = i_lane_a.day_num - i_lane_b.day_num;
        end else begin
            diff = i_lane_b.day_num - i_lane_a.day_num;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rsp.day_count    <= (i_lane_a.ok && i_lane_b.ok) ? diff : '0;
        o_rsp.first_valid  <= i_lane_a.ok;
        o_rsp.second_valid <= i_lane_b.ok;
    end

endmodule

// ===== design/gregorian_day_difference.sv =====
// top level of the gregorian day difference block
//
// a request carries two dates (year, month, day) on i_req and is taken at any
// rising edge with i_start high; o_busy is always low, so one request may be
// issued every cycle.
// two date lanes check and number each date in three register stages, then
// a merge stage forms the absolute difference: the result appears on o_rsp
// with o_strobe high for one cycle, from the merge register, and
// is taken at the edge that follows.
// throughput is one request per cycle, set by the fully pipelined lanes.
// the result is not held: the receiver must take it in that cycle, and it
// cannot stall the block.
// the current year register is written through i_cfg_valid / o_cfg_ready
// (ready is always high) and should only change with no request in flight.
// a synchronous low on i_rst_n drops any results in flight and sets the
// current year back to 2024.
module gregorian_day_difference import gdd_pkg::*; #(
    parameter int YEAR_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  t_gdd_req          i_req,
    output logic              o_strobe,
    output t_gdd_rsp          o_rsp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [YEAR_W-1:0] i_cfg_data
);

    localparam int YB = (YEAR_BITS < YEAR_W) ? YEAR_BITS : YEAR_W;
    localparam logic [YEAR_W-1:0] YMASK = YEAR_W'((1 << YB) - 1);
    localparam int LAT = 4;

    logic [YEAR_W-1:0] r_cur_year;
    logic [LAT-1:0]    r_vld;
    t_gdd_lane         lane_a;
    t_gdd_lane         lane_b;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_year <= RESET_CUR_YEAR & YMASK;
            r_vld      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cur_year <= i_cfg_data & YMASK;
            end
            r_vld <= {r_vld[LAT-2:0], i_start};
        end
    end

    gdd_lane #(.YEAR_BITS(YEAR_BITS)) u_lane_a (
        .i_clk      (i_clk),
        .i_year     (i_req.first_year),
        .i_month    (i_req.first_month),
        .i_day      (i_req.first_day),
        .i_cur_year (r_cur_year),
        .o_lane     (lane_a)
    );

    gdd_lane #(.YEAR_BITS(YEAR_BITS)) u_lane_b (
        .i_clk      (i_clk),
        .i_year     (i_req.second_year),
        .i_month    (i_req.second_month),
        .i_day      (i_req.second_day),
        .i_cur_year (r_cur_year),
        .o_lane     (lane_b)
    );

    gdd_merge u_merge (
        .i_clk    (i_clk),
        .i_lane_a (lane_a),
        .i_lane_b (lane_b),
        .o_rsp    (o_rsp)
    );

endmodule
